// ===== rtl/kws_pkg.sv =====
`timescale 1ns / 1ps
package kws_pkg;

   localparam int unsigned LETTERS = 26;
   localparam int unsigned IDX_W   = 5;

   // request kinds carried on req_tuser
   localparam logic [1:0] MODE_CLEAR   = 2'd0;
   localparam logic [1:0] MODE_ADD     = 2'd1;
   localparam logic [1:0] MODE_SEAL    = 2'd2;
   localparam logic [1:0] MODE_CIPHER  = 2'd3;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LETTERS - 1);
   localparam logic [IDX_W-1:0] FULL_CNT = IDX_W'(LETTERS);

   typedef struct packed {
      logic clear;       // empty the key
      logic add;         // append keyword letter from the request
      logic seal_step;   // try one letter of the seal walk
      logic load;        // capture an enciphered item into the output register
   } cmd_type;

   typedef struct packed {
      logic             walk_last;
      logic             sealed;
      logic [IDX_W-1:0] key_count;
   } status_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } letter_type;

   // alphabet index of a letter of either case
   function automatic letter_type letter_index(input logic [7:0] c);
      letter_type r;
      r.valid = 1'b0;
      r.idx   = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r.valid = 1'b1;
         r.idx   = IDX_W'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r.valid = 1'b1;
         r.idx   = IDX_W'(c - 8'h61);
      end
      return r;
   endfunction

endpackage

// ===== rtl/keyword_substitution_cipher.sv =====
`timescale 1ns / 1ps
// Keyword substitution cipher over A-Z.
// An encipher item shows on rsp in the cycle after it is accepted.
// Clear, keyword and encipher items are taken whenever the output slot is free or draining;
//   a seal item walks the alphabet through the append port and holds off new items until done.
// Reset: synchronous, active high; clears the key, the used set and the output valid.
module keyword_substitution_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_char
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_char
   output logic        rsp_tuser    // [0] key_ready
);

   kws_pkg::cmd_type    cmd;
   kws_pkg::status_type status;

   // controller: accept/hold decisions, seal sequencing, output valid
   kws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // datapath: key table, used set, fill count, seal walk, output register
   kws_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_char   (req_tdata),
      .out_char  (rsp_tdata),
      .key_ready (rsp_tuser)
   );

`ifndef SYNTHESIS
   // the seal walk holds off new items
   assert property (@(posedge clock) disable iff (reset)
      cmd.seal_step |-> !req_tready)
      else $error("item accepted during seal walk");

   // a finished walk leaves a complete, sealed key
   assert property (@(posedge clock) disable iff (reset)
      cmd.seal_step && status.walk_last |=>
         status.sealed && (status.key_count == kws_pkg::FULL_CNT))
      else $error("seal walk ended with incomplete key");

   // fill count never passes the alphabet size
   assert property (@(posedge clock) disable iff (reset)
      status.key_count <= kws_pkg::FULL_CNT)
      else $error("key count overflow");

   // substitution only comes from a sealed key
   assert property (@(posedge clock) disable iff (reset)
      cmd.load && $past(1'b1) |=> (rsp_tuser |-> status.sealed || $past(cmd.clear)))
      else $error("key_ready without sealed key");
`endif

endmodule

// ===== rtl/kws_ctrl.sv =====
`timescale 1ns / 1ps
module kws_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [1:0]         req_mode,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output kws_pkg::cmd_type   cmd,
   input  kws_pkg::status_type status
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SEAL = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   // a new item needs the output slot free or draining this cycle
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  kws_pkg::MODE_CLEAR:  cmd.clear = 1'b1;
                  kws_pkg::MODE_ADD:    cmd.add   = 1'b1;
                  kws_pkg::MODE_SEAL:   state_in  = ST_SEAL;
                  kws_pkg::MODE_CIPHER: begin
                     cmd.load     = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_SEAL: begin
            cmd.seal_step = 1'b1;
            if (status.walk_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/kws_dp.sv =====
`timescale 1ns / 1ps
module kws_dp (
   input  logic                clock,
   input  logic                reset,
   input  kws_pkg::cmd_type    cmd,
   output kws_pkg::status_type status,
   input  logic [7:0]          in_char,
   output logic [7:0]          out_char,
   output logic                key_ready
);

   logic [kws_pkg::IDX_W-1:0] key_table_ff [kws_pkg::LETTERS];
   logic [kws_pkg::LETTERS-1:0] used_ff, used_in;
   logic [kws_pkg::IDX_W-1:0]   count_ff, count_in;
   logic [kws_pkg::IDX_W-1:0]   walk_ff, walk_in;
   logic                        sealed_ff, sealed_in;
   logic [7:0]                  out_char_ff, out_char_in;
   logic                        key_ready_ff, key_ready_in;

   kws_pkg::letter_type       letter;
   logic                      app_try;
   logic [kws_pkg::IDX_W-1:0] app_idx;
   logic                      app_do;

   assign letter = kws_pkg::letter_index(in_char);

   // one append port shared by keyword letters and the seal walk
   assign app_try = (cmd.add && letter.valid) || cmd.seal_step;
   assign app_idx = cmd.seal_step ? walk_ff : letter.idx;
   assign app_do  = app_try && !used_ff[app_idx] && (count_ff < kws_pkg::FULL_CNT);

   always_comb begin
      used_in      = used_ff;
      count_in     = count_ff;
      walk_in      = walk_ff;
      sealed_in    = sealed_ff;
      out_char_in  = out_char_ff;
      key_ready_in = key_ready_ff;
      if (cmd.clear) begin
         used_in   = '0;
         count_in  = '0;
         sealed_in = 1'b0;
      end
      if (app_do) begin
         used_in[app_idx] = 1'b1;
         count_in         = count_ff + 1'b1;
      end
      if (cmd.seal_step) begin
         if (walk_ff == kws_pkg::LAST_IDX) begin
            walk_in   = '0;
            sealed_in = 1'b1;
         end else begin
            walk_in = walk_ff + 1'b1;
         end
      end
      if (cmd.load) begin
         if (sealed_ff && letter.valid) begin
            out_char_in  = 8'h41 + {3'b000, key_table_ff[letter.idx]};
            key_ready_in = 1'b1;
         end else begin
            out_char_in  = in_char;
            key_ready_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         count_ff  <= '0;
         walk_ff   <= '0;
         sealed_ff <= 1'b0;
      end else begin
         used_ff   <= used_in;
         count_ff  <= count_in;
         walk_ff   <= walk_in;
         sealed_ff <= sealed_in;
      end
   end

   // key entries are read only once sealed, when all of them have been written
   always_ff @(posedge clock) begin
      if (app_do) begin
         key_table_ff[count_ff] <= app_idx;
      end
      out_char_ff  <= out_char_in;
      key_ready_ff <= key_ready_in;
   end

   assign out_char         = out_char_ff;
   assign key_ready        = key_ready_ff;
   assign status.walk_last = (walk_ff == kws_pkg::LAST_IDX);
   assign status.sealed    = sealed_ff;
   assign status.key_count = count_ff;

endmodule
